// ===== hw/rtl/suks_pkg.sv =====
package suks_pkg;

   // search and update sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PROBE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_RESULT
   } seq_state_type;

   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_INSERT = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // memory access request from sequencer to key memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/suks_key_mem.sv =====
module suks_key_mem #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 32,
   parameter int ADDR_BITS = 6
) (
   input  logic                    clock,
   input  suks_pkg::mem_ctl_type   ctl,
   input  logic [ADDR_BITS-1:0]    rd_addr,
   input  logic [ADDR_BITS-1:0]    wr_addr,
   input  logic [KEY_BITS-1:0]     wr_data,
   output logic [KEY_BITS-1:0]     rd_data
);
   import suks_pkg::*;

   logic [KEY_BITS-1:0] mem [DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sorted_unique_key_set.sv =====
// sorted set of distinct keys held in ascending order in one key memory
// req channel: tdata = {key[32], action[1]} from bit 0; one item at a time
// rsp channel: one item per request: found, position, added, status, count_after
// csr channel: one bit, 0 unsigned key order, 1 two's complement key order
// a request runs a binary search, each probe a memory read and then a
// compare, at most floor(log2(count))+1 probes; a hit goes straight to the
// result; a miss goes to the place state, and an insert below the top first
// moves each later key up one place, through a read state and a write state
// per key, and then writes the new key in the place state
// the result is valid in the cycle after the result state is entered, and
// after each taken result the block returns to idle to accept the next request
// reset empties the set (count to zero) and clears the order to unsigned;
// memory contents are not cleared, only entries below the count are read
// the result sits in an output register until taken; while rsp is stalled
// the block holds the result and takes no new request
module sorted_unique_key_set #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action[0], key[32:1], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found[0], position[7:1], added[8],
                                    // status[9], count_after[16:10], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import suks_pkg::*;

   localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int IDX_BITS  = CNT_BITS + 1;

   seq_state_type state_ff, state_in;

   logic                order_ff;
   logic                action_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in, ptr_ff, ptr_in;
   logic                found_ff, found_in;
   logic                added_ff, added_in;
   logic                status_ff, status_in;
   logic [KEY_BITS-1:0] move_ff;

   mem_ctl_type         mctl;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic [KEY_BITS-1:0] wr_data, rd_data;
   logic [IDX_BITS-1:0] mid_calc;
   logic [KEY_BITS-1:0] probe_v, held_v, sign_mask;
   logic                eq, lt;
   logic                rsp_valid_ff;

   suks_key_mem #(
      .DEPTH(CAPACITY), .KEY_BITS(KEY_BITS), .ADDR_BITS(ADDR_BITS)
   ) u_mem (
      .clock(clock), .ctl(mctl), .rd_addr(rd_addr), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;

   // order compare: flip sign bit for signed order
   assign sign_mask = {order_ff, {(KEY_BITS-1){1'b0}}};
   assign probe_v   = key_ff ^ sign_mask;
   assign held_v    = rd_data ^ sign_mask;
   assign eq        = (probe_v == held_v);
   assign lt        = (probe_v < held_v);
   assign mid_calc  = IDX_BITS'((low_ff + high_ff) >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (count_ff == '0) ? ST_PLACE : ST_READ;
            end
         end
         ST_READ:  state_in = ST_PROBE;
         ST_PROBE: begin
            if (eq) begin
               state_in = ST_RESULT;
            end else if (lt ? (mid_ff == low_ff) : (mid_ff == high_ff)) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            state_in = ((ptr_ff - CNT_BITS'(1)) == pos_ff) ? ST_PLACE : ST_SHIFT_RD;
         end
         ST_PLACE: begin
            if (action_ff != ACTION_INSERT || count_ff == CNT_BITS'(CAPACITY)
                || ptr_ff == pos_ff || ptr_ff == '1) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_RESULT: state_in = (rsp_valid_ff && rsp_tready) ? ST_IDLE : ST_RESULT;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      added_in     = added_ff;
      status_in    = status_ff;
      mctl         = '0;
      rd_addr      = mid_ff[ADDR_BITS-1:0];
      wr_addr      = ptr_ff[ADDR_BITS-1:0];
      wr_data      = move_ff;
      unique case (state_ff)
         ST_IDLE: begin
            low_in    = '0;
            high_in   = IDX_BITS'(count_ff) - IDX_BITS'(1);
            found_in  = 1'b0;
            added_in  = 1'b0;
            status_in = STATUS_OK;
            pos_in    = '0;
            ptr_in    = '1;
         end
         ST_READ: begin
            mid_in  = mid_calc;
            rd_addr = mid_calc[ADDR_BITS-1:0];
            mctl.rd_en = 1'b1;
         end
         ST_PROBE: begin
            if (eq) begin
               found_in = 1'b1;
               pos_in   = CNT_BITS'(mid_ff);
            end else if (lt) begin
               high_in      = mid_ff - IDX_BITS'(1);
               pos_in       = CNT_BITS'(mid_ff);
            end else begin
               low_in       = mid_ff + IDX_BITS'(1);
               pos_in       = CNT_BITS'(mid_ff + IDX_BITS'(1));
            end
            ptr_in = count_ff;
         end
         ST_SHIFT_RD: begin
            rd_addr    = ADDR_BITS'(ptr_ff - CNT_BITS'(1));
            mctl.rd_en = 1'b1;
         end
         ST_SHIFT_WR: begin
            wr_addr    = ptr_ff[ADDR_BITS-1:0];
            wr_data    = rd_data;
            mctl.wr_en = 1'b1;
            ptr_in     = ptr_ff - CNT_BITS'(1);
         end
         ST_PLACE: begin
            if (action_ff == ACTION_INSERT) begin
               if (count_ff == CNT_BITS'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else if (ptr_ff == pos_ff || ptr_ff == '1) begin
                  wr_addr    = pos_ff[ADDR_BITS-1:0];
                  wr_data    = key_ff;
                  mctl.wr_en = 1'b1;
                  added_in   = 1'b1;
                  count_in   = count_ff + CNT_BITS'(1);
               end
            end
            if (ptr_ff == '1) begin
               ptr_in = pos_ff;
            end
         end
         ST_RESULT: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_data;
         end
         if (state_ff == ST_RESULT && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff <= req_tdata[0];
         key_ff    <= req_tdata[KEY_BITS:1];
      end
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      pos_ff       <= pos_in;
      ptr_ff       <= ptr_in;
      found_ff     <= found_in;
      added_ff     <= added_in;
      status_ff    <= status_in;
      move_ff      <= rd_data;
   end

   assign rsp_tdata = {7'b0, 7'(count_ff), status_ff, added_ff, 7'(pos_ff), found_ff};

   // result item held steady while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)));

   // no request taken while a result waits
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid));

   // entry count never passes the capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_BITS'(CAPACITY));

   // a result is offered only from the result state
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == ST_RESULT));

endmodule
